>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the edge filter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

>>> design/l3e_pkg.sv
// ----------------------------------------------------------------------------
// l3e_pkg
// Types and constants of the 3x3 Laplacian edge filter.
// ----------------------------------------------------------------------------
package l3e_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int PIX_W         = 8;
   localparam int ROW_W         = 12;
   localparam int OUT_COL_W     = 11;
   localparam int CFG_W_W       = 12;
   localparam int CFG_H_W       = 13;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = 13;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 32;

   localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [CFG_H_W-1:0] HEIGHT_LIMIT = 13'd4096;
   localparam int                 MIN_DIM      = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef logic [PIX_W-1:0] pixel_type;

   // one window column: rows r-2, r-1, r
   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   // line store entry: line r-1 and line r-2 at one column
   typedef struct packed {
      pixel_type middle;
      pixel_type upper;
   } line_entry_type;

endpackage

>>> design/l3e_line_buffer.sv
// ----------------------------------------------------------------------------
// l3e_line_buffer
// Two line stores in one memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module l3e_line_buffer #(
   parameter int DEPTH = l3e_pkg::MAX_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output l3e_pkg::line_entry_type rd_data,
   input  logic                    wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  l3e_pkg::line_entry_type wr_data
);

   l3e_pkg::line_entry_type mem [DEPTH];
   l3e_pkg::line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/l3e_tap_cell.sv
// ----------------------------------------------------------------------------
// l3e_tap_cell
// One column of the 3x3 window; takes a column and hands it to its neighbor.
// ----------------------------------------------------------------------------
module l3e_tap_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  l3e_pkg::column_type col_i,
   output l3e_pkg::column_type col_o
);

   l3e_pkg::column_type col_ff;
   l3e_pkg::column_type col_in;

   always_comb begin
      col_in = shift ? col_i : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign col_o = col_ff;

endmodule

>>> design/laplacian_3x3_edge_filter.sv
// ----------------------------------------------------------------------------
// laplacian_3x3_edge_filter
// Four-neighbor Laplacian edge filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output register is empty or being taken;
// a result is registered in the window stage and then in the output register. The
// rate is set by the single line memory, which is read and written once per
// pixel, with a bypass for back-to-back hits on the same column. Border pixels
// give no result. The line memory needs no clearing after reset.
module laplacian_3x3_edge_filter #(
   parameter int MAX_WIDTH = l3e_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [l3e_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] pixel_value
   input  logic                            req_tuser,  // [0] frame_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] edge_value, [18:8] out_column, [30:19] out_row, [31] zero
   output logic [l3e_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,  // frame_last
   input  logic                            csr_we,
   input  logic [l3e_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [l3e_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int NW = (CW + 1 > l3e_pkg::CFG_W_W) ? CW + 1 : l3e_pkg::CFG_W_W;
   localparam int RW = l3e_pkg::ROW_W;
   localparam int HW = l3e_pkg::CFG_H_W;
   localparam logic [NW-1:0] MAX_W_N = NW'(MAX_WIDTH);
   localparam int RSP_DATA_W_L = l3e_pkg::RSP_DATA_W;

   // configuration
   logic [l3e_pkg::CFG_W_W-1:0] width_ff, width_in;
   logic [HW-1:0]               height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            l3e_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata[l3e_pkg::CFG_W_W-1:0];
            l3e_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= l3e_pkg::WIDTH_RESET;
         height_ff <= l3e_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   logic [NW-1:0] width_n, w_eff;
   logic [HW-1:0] h_eff;

   always_comb begin
      width_n = NW'(width_ff);
      if (width_n < NW'(l3e_pkg::MIN_DIM)) begin
         w_eff = NW'(l3e_pkg::MIN_DIM);
      end else if (width_n > MAX_W_N) begin
         w_eff = MAX_W_N;
      end else begin
         w_eff = width_n;
      end
      if (height_ff < HW'(l3e_pkg::MIN_DIM)) begin
         h_eff = HW'(l3e_pkg::MIN_DIM);
      end else if (height_ff > l3e_pkg::HEIGHT_LIMIT) begin
         h_eff = l3e_pkg::HEIGHT_LIMIT;
      end else begin
         h_eff = height_ff;
      end
   end

   // handshake
   logic out_valid_ff, out_valid_in;
   logic adv, accept;

   assign adv        = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && adv;
   assign req_tready = adv;

   // raster position of the arriving pixel
   logic [CW-1:0] col_ff, col_in, c0, ca;
   logic [RW-1:0] row_ff, row_in, r0, ra;
   logic [HW-1:0] r1, rn;
   logic [NW-1:0] cn;
   logic          wrap0, wrap1, a_interior, a_last;

   always_comb begin
      c0    = req_tuser ? '0 : col_ff;
      r0    = req_tuser ? '0 : row_ff;
      wrap0 = NW'(c0) >= w_eff;
      ca    = wrap0 ? '0 : c0;
      r1    = wrap0 ? {1'b0, r0} + HW'(1) : {1'b0, r0};
      ra    = (r1 >= h_eff) ? '0 : r1[RW-1:0];
      cn    = NW'(ca) + NW'(1);
      wrap1 = cn >= w_eff;
      rn    = {1'b0, ra} + HW'(1);
      a_interior = (NW'(ca) >= NW'(2)) && (ra >= RW'(2));
      a_last     = (NW'(ca) == w_eff - NW'(1)) && ({1'b0, ra} == h_eff - HW'(1));
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = wrap1 ? '0 : cn[CW-1:0];
         row_in = wrap1 ? ((rn >= h_eff) ? '0 : rn[RW-1:0]) : ra;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // window stage
   logic                    b_valid_ff;
   logic                    b_fwd_ff;
   l3e_pkg::line_entry_type b_fwd_data_ff;
   l3e_pkg::pixel_type      b_pix_ff;
   logic [CW-1:0]           b_col_ff;
   logic [RW-1:0]           b_row_ff;
   logic                    b_interior_ff, b_last_ff;

   l3e_pkg::line_entry_type rd_entry, entry, wr_entry;
   l3e_pkg::column_type     tap0_col, tap1_col, new_col;

   always_comb begin
      entry           = b_fwd_ff ? b_fwd_data_ff : rd_entry;
      wr_entry.middle = b_pix_ff;
      wr_entry.upper  = entry.middle;
      new_col.top     = entry.upper;
      new_col.mid     = entry.middle;
      new_col.bot     = b_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_fwd_ff      <= b_valid_ff && (b_col_ff == ca);
         b_fwd_data_ff <= wr_entry;
         b_pix_ff      <= req_tdata[l3e_pkg::PIX_W-1:0];
         b_col_ff      <= ca;
         b_row_ff      <= ra;
         b_interior_ff <= a_interior;
         b_last_ff     <= a_last;
      end
   end

   l3e_line_buffer #(
      .DEPTH(MAX_WIDTH)
   ) u_line_buffer (
      .clock  (clock),
      .rd_en  (adv),
      .rd_addr(ca),
      .rd_data(rd_entry),
      .wr_en  (adv && b_valid_ff),
      .wr_addr(b_col_ff),
      .wr_data(wr_entry)
   );

   l3e_tap_cell u_tap0 (
      .clock(clock),
      .reset(reset),
      .shift(adv && b_valid_ff),
      .col_i(new_col),
      .col_o(tap0_col)
   );

   l3e_tap_cell u_tap1 (
      .clock(clock),
      .reset(reset),
      .shift(adv && b_valid_ff),
      .col_i(tap0_col),
      .col_o(tap1_col)
   );

   // Laplacian kernel
   logic [9:0]              sum4, centre4, diff;
   l3e_pkg::pixel_type      edge_v;
   logic [NW-1:0]           col_m1;
   logic [RW-1:0]           row_m1;
   logic [RSP_DATA_W_L-1:0] out_data_ff, out_data_in;
   logic                    out_last_ff, out_last_in;

   always_comb begin
      sum4    = 10'(tap0_col.top) + 10'(tap0_col.bot) + 10'(tap1_col.mid)
              + 10'(entry.middle);
      centre4 = {tap0_col.mid, 2'b00};
      diff    = (sum4 >= centre4) ? sum4 - centre4 : centre4 - sum4;
      edge_v  = (diff > 10'd255) ? 8'hFF : diff[7:0];
      col_m1  = NW'(b_col_ff) - NW'(1);
      row_m1  = b_row_ff - RW'(1);
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (adv) begin
         out_valid_in = b_valid_ff && b_interior_ff;
         out_data_in  = {1'b0, row_m1, col_m1[l3e_pkg::OUT_COL_W-1:0], edge_v};
         out_last_in  = b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> design/l3e_checker.sv
// ----------------------------------------------------------------------------
// l3e_checker
// Port-level checks of the edge filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module l3e_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [l3e_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast
);

   logic rsp_stall;
   logic req_xact;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_xact  = req_tvalid && req_tready;

   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // input side never stalls while the output register can move
   `ASSERT_IMP(a_req_ready, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))

   // results are interior pixels only
   `ASSERT_IMP(a_interior, clock, reset, rsp_tvalid,
      (rsp_tdata[18:8] != 11'd0) && (rsp_tdata[30:19] != 12'd0) && !rsp_tdata[31])

   // a new result traces back to an input transaction through the window stage
   `ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_tvalid), $past(req_xact, 2))

endmodule

bind laplacian_3x3_edge_filter l3e_checker u_l3e_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

>>> dv/tb_laplacian_3x3_edge_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laplacian_3x3_edge_filter
// Streams raster frames of random pixels into the edge filter. A local
// predictor computes the four-neighbor response of every interior pixel, and
// each result transaction is checked against it. Several frame sizes are used,
// clamped ones among them. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_laplacian_3x3_edge_filter;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [l3e_pkg::CSR_ADDR_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [l3e_pkg::CSR_ADDR_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic [l3e_pkg::PIX_W-1:0]     edge_value;
      logic [l3e_pkg::OUT_COL_W-1:0] column;
      logic [l3e_pkg::ROW_W-1:0]     row;
      logic                          last;
   } edge_result_type;

   class edge_result_board;
      int unsigned         width_reg;
      int unsigned         height_reg;
      l3e_pkg::pixel_type  upper_line [l3e_pkg::MAX_WIDTH_DEF];
      l3e_pkg::pixel_type  middle_line [l3e_pkg::MAX_WIDTH_DEF];
      l3e_pkg::pixel_type  taps [6];
      int unsigned         column;
      int unsigned         row;
      edge_result_type     pending_edges [$];
      int unsigned         mismatches;

      function void clear();
         width_reg  = l3e_pkg::WIDTH_RESET;
         height_reg = l3e_pkg::HEIGHT_RESET;
         foreach (upper_line[i]) upper_line[i] = '0;
         foreach (middle_line[i]) middle_line[i] = '0;
         foreach (taps[i]) taps[i] = '0;
         column = 0;
         row = 0;
         mismatches = 0;
         pending_edges.delete();
      endfunction

      function void write_reg(logic [l3e_pkg::CSR_ADDR_W-1:0] index,
                              logic [l3e_pkg::CSR_DATA_W-1:0] value);
         unique case (index)
            l3e_pkg::CSR_IMAGE_WIDTH:  width_reg = value[l3e_pkg::CFG_W_W-1:0];
            l3e_pkg::CSR_IMAGE_HEIGHT: height_reg = value[l3e_pkg::CFG_H_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         if (width_reg < l3e_pkg::MIN_DIM) return l3e_pkg::MIN_DIM;
         if (width_reg > l3e_pkg::MAX_WIDTH_DEF) return l3e_pkg::MAX_WIDTH_DEF;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         if (height_reg < l3e_pkg::MIN_DIM) return l3e_pkg::MIN_DIM;
         if (height_reg > l3e_pkg::HEIGHT_LIMIT) return l3e_pkg::HEIGHT_LIMIT;
         return height_reg;
      endfunction

      function void note_pixel(l3e_pkg::pixel_type pix, logic frame_start);
         int unsigned         w;
         int unsigned         h;
         int unsigned         c;
         int unsigned         r;
         int                  sum;
         l3e_pkg::pixel_type  top;
         l3e_pkg::pixel_type  mid;
         edge_result_type     res;
         w = eff_width();
         h = eff_height();
         if (frame_start) begin
            column = 0;
            row = 0;
         end
         if (column >= w) begin
            column = 0;
            row++;
         end
         if (row >= h) row = 0;
         c = column;
         r = row;
         top = upper_line[c];
         mid = middle_line[c];
         if (c >= 2 && r >= 2) begin
            sum = int'(taps[0]) + int'(taps[2]) + int'(taps[4]) + int'(mid)
                - 4 * int'(taps[1]);
            if (sum < 0) sum = -sum;
            if (sum > 255) sum = 255;
            res.edge_value = 8'(sum);
            res.column = 11'(c - 1);
            res.row = 12'(r - 1);
            res.last = (c == w - 1) && (r == h - 1);
            pending_edges.push_back(res);
         end
         taps[3] = taps[0];
         taps[4] = taps[1];
         taps[5] = taps[2];
         taps[0] = top;
         taps[1] = mid;
         taps[2] = pix;
         upper_line[c] = mid;
         middle_line[c] = pix;
         column = c + 1;
         if (column >= w) begin
            column = 0;
            row = r + 1;
            if (row >= h) row = 0;
         end
      endfunction

      task report(string what, int got, int want);
         mismatches++;
         $display("mismatch %s: got %0d expected %0d", what, got, want);
      endtask

      task check_result(logic [l3e_pkg::RSP_DATA_W-1:0] data, logic last);
         edge_result_type want;
         if (pending_edges.size() == 0) begin
            report("unexpected transaction", int'(data), 0);
            return;
         end
         want = pending_edges.pop_front();
         if (data[7:0] !== want.edge_value)
            report("edge_value", int'(data[7:0]), int'(want.edge_value));
         if (data[18:8] !== want.column)
            report("out_column", int'(data[18:8]), int'(want.column));
         if (data[30:19] !== want.row)
            report("out_row", int'(data[30:19]), int'(want.row));
         if (data[31] !== 1'b0) report("pad bit", int'(data[31]), 0);
         if (last !== want.last) report("frame_last", int'(last), int'(want.last));
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [l3e_pkg::REQ_DATA_W-1:0]   req_tdata = '0;   // [7:0] pixel_value
   logic                             req_tuser = 1'b0; // [0] frame_start
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // [7:0] edge, [18:8] col, [30:19] row, [31] 0
   logic [l3e_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tlast;        // frame_last
   logic                             csr_we = 1'b0;
   logic [l3e_pkg::CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [l3e_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   edge_result_board board;
   int unsigned      items_sent = 0;
   int unsigned      cycle_count = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;

   laplacian_3x3_edge_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_laplacian_3x3_edge_filter: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic l3e_pkg::pixel_type pick_pixel();
      unique case ($urandom_range(9))
         0, 1: return 8'd0;
         2, 3: return 8'd255;
         4: return 8'($urandom_range(15));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [l3e_pkg::CSR_DATA_W-1:0] pick_width();
      unique case ($urandom_range(9))
         0: return 13'($urandom_range(0, 2));
         1: return 13'h1000 | 13'($urandom_range(3, 8));  // bit 12 is dropped
         2: return 13'($urandom_range(11, 40));
         default: return 13'($urandom_range(3, 10));
      endcase
   endfunction

   function automatic logic [l3e_pkg::CSR_DATA_W-1:0] pick_height();
      unique case ($urandom_range(9))
         0: return 13'($urandom_range(0, 2));
         1: return 13'($urandom_range(4097, 8191));
         default: return 13'($urandom_range(3, 8));
      endcase
   endfunction

   task automatic send_pixel(input l3e_pkg::pixel_type pix, input logic frame_start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= frame_start;
      do @(posedge clock); while (!req_tready);
      board.note_pixel(pix, frame_start);
      items_sent++;
   endtask

   // only called while the filter is idle
   task automatic write_csr(input logic [l3e_pkg::CSR_ADDR_W-1:0] index,
                            input logic [l3e_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_items(input int count, input bit force_start, input bit clean);
      logic frame_start;
      for (int i = 0; i < count; i++) begin
         if (i == 0 && force_start) frame_start = 1'b1;
         else if (clean) frame_start = 1'b0;
         else if (board.column == 0 && board.row == 0) frame_start = ($urandom_range(9) < 7);
         else frame_start = ($urandom_range(99) < 3);
         send_pixel(pick_pixel(), frame_start);
      end
   endtask

   // a wider line must restart the frame, or stale line entries would be read
   task automatic random_phase();
      int unsigned old_width;
      int unsigned sel;
      old_width = board.eff_width();
      sel = $urandom_range(9);
      if (sel < 6) write_csr(l3e_pkg::CSR_IMAGE_WIDTH, pick_width());
      if (sel < 3 || sel == 6 || sel == 7) write_csr(l3e_pkg::CSR_IMAGE_HEIGHT, pick_height());
      if (sel == 8)
         write_csr($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, 13'($urandom_range(8191)));
      run_items($urandom_range(20, 60), board.eff_width() > old_width, 1'b0);
      settle();
   endtask

   initial begin
      board = new();
      board.clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 21;
      recv_idle_pct = 81;

      // spare indexes must not touch the size registers
      write_csr(CSR_SPARE_LO, 13'h1FFF);
      write_csr(CSR_SPARE_HI, 13'h0002);
      write_csr(l3e_pkg::CSR_IMAGE_WIDTH, 13'd3);
      write_csr(l3e_pkg::CSR_IMAGE_HEIGHT, 13'd3);
      // dark center in bright ring, then the inverse after a natural wrap
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd0 : 8'd255, i == 0);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'd255 : 8'd0, 1'b0);
      settle();
      write_csr(l3e_pkg::CSR_IMAGE_WIDTH, 13'h1001);
      write_csr(l3e_pkg::CSR_IMAGE_HEIGHT, 13'd0);

      while (items_sent < 210) random_phase();
      send_idle_pct = 81;
      recv_idle_pct = 21;
      while (items_sent < 410) random_phase();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (items_sent < 570) random_phase();

      // widest line, then tallest frame, a short clean run each
      write_csr(l3e_pkg::CSR_IMAGE_WIDTH, 13'd4095);
      write_csr(l3e_pkg::CSR_IMAGE_HEIGHT, 13'd3);
      run_items(30, 1'b1, 1'b1);
      settle();
      write_csr(l3e_pkg::CSR_IMAGE_WIDTH, 13'd3);
      write_csr(l3e_pkg::CSR_IMAGE_HEIGHT, 13'd8191);
      run_items(36, 1'b1, 1'b1);
      settle();

      if (board.pending_edges.size() == 0 && board.mismatches == 0)
         $display("tb_laplacian_3x3_edge_filter: PASS");
      else
         $display("tb_laplacian_3x3_edge_filter: FAIL");
      $finish;
   end

endmodule
